// ----- rtl/lpap_pkg.sv -----
`timescale 1ns / 1ps

package lpap_pkg;

    // width of the file position counter
    localparam int POSITION_BITS = 32;
    // working width for the payload start subtraction
    localparam int WIDE_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam logic [WIDE_BITS-1:0] POS_MASK =
        {WIDE_BITS{1'b1}} >> (WIDE_BITS - POSITION_BITS);

    localparam logic [31:0] STORED_MARK = 32'hFFFF_FFFF;
    localparam logic [7:0]  NAME_LOW    = 8'h20;
    localparam logic [7:0]  NAME_HIGH   = 8'h7e;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_LEN     = 3'd0,
        PH_NAME    = 3'd1,
        PH_DSIZE   = 3'd2,
        PH_CSIZE   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_FAILED  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_ZERO_LEN   = 3'd1,
        ERR_BAD_NAME   = 3'd2,
        ERR_TRUNCATED  = 3'd3,
        ERR_NO_ENTRIES = 3'd4,
        ERR_TOO_LONG   = 3'd5
    } err_code_t;

    typedef enum logic [1:0] {
        KIND_ENTRY  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  name_length;
        logic [31:0] inflated_size;
        logic [31:0] payload_start;
        logic [31:0] payload_length;
        logic        stored_flag;
        logic [31:0] entry_number;
        err_code_t   error_code;
        logic        last_of_run;
    } out_word_t;

    // up to two result words produced by one byte
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } parse_res_t;

endpackage

// ----- rtl/lpap_parse.sv -----
`timescale 1ns / 1ps

module lpap_parse import lpap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  in_word_t   word,
    output parse_res_t res
);

    phase_t                   phase_reg, phase_next;
    logic [7:0]               field_cnt_reg, field_cnt_next;
    logic [7:0]               name_size_reg, name_size_next;
    logic [31:0]              decomp_reg, decomp_next;
    logic [31:0]              comp_reg, comp_next;
    logic [31:0]              remain_reg, remain_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [31:0]              entries_reg, entries_next;
    err_code_t                first_err_reg, first_err_next;

    logic [7:0]               b;
    logic                     fin;
    logic [POSITION_BITS-1:0] pos_inc;
    logic                     wrap;
    logic [7:0]               cnt_inc, cnt_dec;
    logic                     size_done;
    logic                     name_bad;
    logic [31:0]              merged_decomp, merged_comp;
    logic                     csize_mark;
    logic [31:0]              plen_new;
    logic [31:0]              remain_dec;
    logic                     record;
    err_code_t                err_hit, err_parse, err_after, verdict_code;
    phase_t                   phase_parse, phase_after;
    logic [31:0]              entries_after;
    logic                     rec_stored;
    logic [31:0]              rec_plen;
    logic [WIDE_BITS-1:0]     start_wide;
    out_word_t                rec_word, verdict_word;

    function automatic logic [31:0] merge_byte(input logic [31:0] base,
                                               input logic [7:0] val,
                                               input logic [1:0] lane);
        logic [31:0] w;
        w = base;
        case (lane)
            2'd0:    w[7:0]   = w[7:0]   | val;
            2'd1:    w[15:8]  = w[15:8]  | val;
            2'd2:    w[23:16] = w[23:16] | val;
            default: w[31:24] = w[31:24] | val;
        endcase
        return w;
    endfunction

    assign b          = word.data_byte;
    assign fin        = word.final_byte;
    assign pos_inc    = pos_reg + POSITION_BITS'(1);
    assign wrap       = (pos_inc == '0);
    assign cnt_inc    = field_cnt_reg + 8'd1;
    assign cnt_dec    = field_cnt_reg - 8'd1;
    assign size_done  = (cnt_inc >= 8'd4);
    assign name_bad   = (b < NAME_LOW) || (b > NAME_HIGH);
    assign merged_decomp = merge_byte(decomp_reg, b, field_cnt_reg[1:0]);
    assign merged_comp   = merge_byte(comp_reg, b, field_cnt_reg[1:0]);
    assign csize_mark = (merged_comp == STORED_MARK);
    assign plen_new   = csize_mark ? decomp_reg : merged_comp;
    assign remain_dec = remain_reg - 32'd1;

    assign record = ((phase_reg == PH_CSIZE) && size_done && (plen_new == '0))
                 || ((phase_reg == PH_PAYLOAD) && (remain_dec == '0));

    assign err_hit = ((phase_reg == PH_LEN) && (b == 8'd0))      ? ERR_ZERO_LEN :
                     ((phase_reg == PH_NAME) && name_bad)        ? ERR_BAD_NAME :
                                                                   ERR_NONE;
    assign err_parse = (first_err_reg != ERR_NONE) ? first_err_reg : err_hit;
    assign err_after = ((err_parse == ERR_NONE) && !fin && wrap) ? ERR_TOO_LONG
                                                                 : err_parse;
    assign entries_after = record ? (entries_reg + 32'd1) : entries_reg;

    // next phase
    always_comb
    begin
        unique case (phase_reg)
            PH_LEN:
                phase_parse = (b == 8'd0) ? PH_FAILED : PH_NAME;
            PH_NAME:
                phase_parse = name_bad ? PH_FAILED
                            : ((cnt_dec == 8'd0) ? PH_DSIZE : PH_NAME);
            PH_DSIZE:
                phase_parse = size_done ? PH_CSIZE : PH_DSIZE;
            PH_CSIZE:
                phase_parse = !size_done ? PH_CSIZE
                            : ((plen_new == '0) ? PH_LEN : PH_PAYLOAD);
            PH_PAYLOAD:
                phase_parse = (remain_dec == '0) ? PH_LEN : PH_PAYLOAD;
            default:
                phase_parse = PH_FAILED;
        endcase
        phase_after = (!fin && wrap) ? PH_FAILED : phase_parse;
        if (!en)
        begin
            phase_next = phase_reg;
        end
        else if (fin)
        begin
            phase_next = PH_LEN;
        end
        else
        begin
            phase_next = phase_after;
        end
    end

    // field registers
    always_comb
    begin
        field_cnt_next = field_cnt_reg;
        name_size_next = name_size_reg;
        decomp_next    = decomp_reg;
        comp_next      = comp_reg;
        remain_next    = remain_reg;
        case (phase_reg)
            PH_LEN:
                if (b != 8'd0)
                begin
                    name_size_next = b;
                    field_cnt_next = b;
                end
            PH_NAME:
                if (!name_bad)
                begin
                    field_cnt_next = cnt_dec;
                    if (cnt_dec == 8'd0)
                    begin
                        decomp_next = '0;
                    end
                end
            PH_DSIZE:
            begin
                decomp_next    = merged_decomp;
                field_cnt_next = size_done ? 8'd0 : cnt_inc;
                if (size_done)
                begin
                    comp_next = '0;
                end
            end
            PH_CSIZE:
            begin
                comp_next      = merged_comp;
                field_cnt_next = size_done ? 8'd0 : cnt_inc;
                if (size_done)
                begin
                    remain_next = plen_new;
                end
            end
            PH_PAYLOAD:
                remain_next = remain_dec;
            default:
            begin
            end
        endcase
        pos_next       = pos_inc;
        entries_next   = entries_after;
        first_err_next = err_after;
        if (fin)
        begin
            field_cnt_next = '0;
            name_size_next = '0;
            decomp_next    = '0;
            comp_next      = '0;
            remain_next    = '0;
            pos_next       = '0;
            entries_next   = '0;
            first_err_next = ERR_NONE;
        end
    end

    // result words
    always_comb
    begin
        rec_stored = (phase_reg == PH_CSIZE) ? csize_mark : (comp_reg == STORED_MARK);
        if (rec_stored)
        begin
            rec_plen = decomp_reg;
        end
        else
        begin
            rec_plen = (phase_reg == PH_CSIZE) ? merged_comp : comp_reg;
        end
        start_wide = (WIDE_BITS'(pos_inc) - WIDE_BITS'(rec_plen)) & POS_MASK;

        verdict_code = err_parse;
        if ((verdict_code == ERR_NONE) && (phase_parse != PH_LEN))
        begin
            verdict_code = ERR_TRUNCATED;
        end
        if ((verdict_code == ERR_NONE) && (entries_after == '0))
        begin
            verdict_code = ERR_NO_ENTRIES;
        end

        rec_word.result_kind       = KIND_ENTRY;
        rec_word.name_length       = name_size_reg;
        rec_word.inflated_size     = decomp_reg;
        rec_word.payload_start     = start_wide[31:0];
        rec_word.payload_length    = rec_plen;
        rec_word.stored_flag       = rec_stored;
        rec_word.entry_number      = entries_reg;
        rec_word.error_code        = ERR_NONE;
        rec_word.last_of_run       = !fin;

        verdict_word.result_kind       = (verdict_code == ERR_NONE) ? KIND_ACCEPT
                                                                    : KIND_REJECT;
        verdict_word.name_length       = '0;
        verdict_word.inflated_size     = '0;
        verdict_word.payload_start     = '0;
        verdict_word.payload_length    = '0;
        verdict_word.stored_flag       = 1'b0;
        verdict_word.entry_number      = entries_after;
        verdict_word.error_code        = verdict_code;
        verdict_word.last_of_run       = 1'b1;

        res.count  = en ? (2'(record) + 2'(fin)) : 2'd0;
        res.first  = record ? rec_word : verdict_word;
        res.second = verdict_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            field_cnt_reg <= '0;
            name_size_reg <= '0;
            decomp_reg    <= '0;
            comp_reg      <= '0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            entries_reg   <= '0;
            first_err_reg <= ERR_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            if (en)
            begin
                field_cnt_reg <= field_cnt_next;
                name_size_reg <= name_size_next;
                decomp_reg    <= decomp_next;
                comp_reg      <= comp_next;
                remain_reg    <= remain_next;
                pos_reg       <= pos_next;
                entries_reg   <= entries_next;
                first_err_reg <= first_err_next;
            end
        end
    end

endmodule

// ----- rtl/lpap_outq.sv -----
`timescale 1ns / 1ps

module lpap_outq import lpap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  parse_res_t push,
    input  logic       pop,
    output out_word_t  head,
    output logic       not_empty,
    output logic       room
);

    out_word_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic [QPTR_BITS-1:0] wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + QPTR_BITS'(1);
    assign wr_ptr_next   = wr_ptr_reg + QPTR_BITS'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + QPTR_BITS'(pop);
    assign cnt_next      = cnt_reg + QCNT_BITS'(push.count) - QCNT_BITS'(pop);

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    // space for two words whatever leaves this cycle
    assign room      = (cnt_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/length_prefixed_archive_parser.sv -----
`timescale 1ns / 1ps
// streaming validator for a length-prefixed archive, one byte word per cycle unless the input stalls
// a byte word passes the input register, then the result queue, before its first result word can be accepted
// throughput: 1 byte per cycle while the result queue has room; a byte that closes an entry and ends the file
//   gives two result words, which leave the result queue one after the other
// input stalls while a byte is held and the result queue holds three or more words
// reset (rst_n low, asynchronous) clears the parse state and empties the queue

module length_prefixed_archive_parser import lpap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // byte channel
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_word_t  byte_word,
    // result channel
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result_word
);

    // input register: holds one byte word until the parser can take it
    in_word_t   byte_reg;
    logic       byte_vld_reg, byte_vld_next;

    logic       room;
    logic       consume;
    logic       take;
    logic       pop;
    parse_res_t res;

    // the parser consumes the held byte only when the queue can absorb two words
    assign consume    = byte_vld_reg && room;
    // upstream waits only while a held byte cannot be consumed
    assign byte_stall = byte_vld_reg && !consume;
    assign take       = byte_valid && !byte_stall;
    assign pop        = result_valid && !result_stall;

    always_comb
    begin
        if (take)
        begin
            byte_vld_next = 1'b1;
        end
        else if (consume)
        begin
            byte_vld_next = 1'b0;
        end
        else
        begin
            byte_vld_next = byte_vld_reg;
        end
    end

    // byte payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
        end
    end

    // parse state machine and result word builder
    lpap_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (consume),
        .word  (byte_reg),
        .res   (res)
    );

    // result queue parts the parser from a stalled consumer
    lpap_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .pop       (pop),
        .head      (result_word),
        .not_empty (result_valid),
        .room      (room)
    );

endmodule
